// ----- rtl/core/setach_pkg.sv -----
package setach_pkg;

    localparam int TRACE_DEPTH_DEF = 16;
    localparam int LOOKBACK_DEF    = 5;

    localparam int NUM_W = 66;
    localparam int DEN_W = 80;
    localparam int IT_W  = 7;

    localparam logic [1:0] OP_PULSE = 2'd0;
    localparam logic [1:0] OP_INDEX = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam logic [1:0] CFG_PPR     = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT = 2'd1;
    localparam logic [1:0] CFG_WINDOW  = 2'd2;

    localparam logic [33:0] RPM_SCALE      = 34'd15360000000;
    localparam logic [33:0] RPM_MAX        = 34'h3_FFFF_FFFF;
    localparam logic [31:0] FRESH_LIMIT_US = 32'd125000;
    localparam logic [15:0] US_PER_MS      = 16'd1000;
    localparam logic [19:0] WINDOW_RESET   = 20'd10000;

    // ceil(2^38 / 1000), exact divide by 1000 for every 32-bit input
    localparam logic [31:0] MS_RECIP       = 32'd274877907;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        logic [IT_W-1:0]  iter;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quo;
        logic [DEN_W-1:0] rem;
    } t_div_rsp;

endpackage

// ----- rtl/core/setach_div.sv -----
module setach_div
    import setach_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic             r_busy;
    logic             r_done;
    logic [IT_W-1:0]  r_cnt;
    logic [NUM_W-1:0] r_num;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;

    logic [DEN_W:0]   n_shift;
    logic             n_ge;
    logic [DEN_W:0]   n_diff;

    // restoring division, one quotient bit per cycle, numerator left aligned
    assign n_shift = {r_rem, r_num[NUM_W-1]};
    assign n_ge    = n_shift >= {1'b0, r_den};
    assign n_diff  = n_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.iter;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == IT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.num;
            r_den <= i_req.den;
            r_quo <= '0;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], 1'b0};
            r_quo <= {r_quo[NUM_W-2:0], n_ge};
            r_rem <= n_ge ? n_diff[DEN_W-1:0] : n_shift[DEN_W-1:0];
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem;

endmodule

// ----- rtl/core/spindle_encoder_tachometer_top.sv -----
// Encoder tachometer: encoder pulses and index pulses are taken without a stall, except a
// pulse that closes a window with a nonzero sum, which stalls the input during the
// 64-step mean-period division. A status query walks the trace ring (one synchronous
// read per slot), forms the serial rpm products, runs the 66-step rpm division and the
// revolution and phase divisions, then takes the millisecond stamp (reciprocal multiply)
// and loads the result; the rpm products and rpm division are skipped when no rpm can be
// given. The trace ring needs no clearing after reset. The input side stalls while an
// item is in work; a finished status result waits in the output register while pulses
// and index pulses keep being taken.
module spindle_encoder_tachometer_top
    import setach_pkg::*;
#(
    parameter int TRACE_DEPTH = TRACE_DEPTH_DEF,
    parameter int LOOKBACK    = LOOKBACK_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_opcode,
    input  logic [31:0]        i_timestamp_us,
    input  logic signed [1:0]  i_direction,
    input  logic [31:0]        i_now_ms,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [31:0]        o_pulse_total,
    output logic [31:0]        o_index_total,
    output logic [31:0]        o_pulses_per_index,
    output logic [31:0]        o_raw_period,
    output logic [31:0]        o_filtered_period,
    output logic [31:0]        o_windows_retired,
    output logic signed [1:0]  o_last_direction,
    output logic [33:0]        o_rpm_fixed,
    output logic [31:0]        o_revolutions,
    output logic [15:0]        o_phase_pulses,
    output logic [31:0]        o_pulse_age_ms,
    output logic [5:0]         o_status_flags
);

    localparam int SLOT_W = (TRACE_DEPTH > 1) ? $clog2(TRACE_DEPTH) : 1;
    localparam int OFF_W  = $clog2(LOOKBACK + 1);
    localparam int MEM_W  = 128;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_FILT = 4'd1;
    localparam logic [3:0] S_WRD  = 4'd2;
    localparam logic [3:0] S_WCHK = 4'd3;
    localparam logic [3:0] S_MSET = 4'd4;
    localparam logic [3:0] S_MUL  = 4'd5;
    localparam logic [3:0] S_DRPM = 4'd6;
    localparam logic [3:0] S_DREV = 4'd7;
    localparam logic [3:0] S_DMOD = 4'd8;
    localparam logic [3:0] S_DMS  = 4'd9;
    localparam logic [3:0] S_DONE = 4'd10;

    // configuration
    logic [15:0] r_ppr;
    logic [31:0] r_timeout;
    logic [19:0] r_window;

    // tracking state
    logic [3:0]  r_state;
    logic [31:0] r_last;
    logic [31:0] r_raw;
    logic [31:0] r_filt;
    logic [31:0] r_pulse_cnt;
    logic [31:0] r_index_cnt;
    logic [31:0] r_pulse_at_index;
    logic [31:0] r_index_span;
    logic [31:0] r_pos;
    logic [31:0] r_pos_at_index;
    logic [31:0] r_index_time;
    logic [1:0]  r_dir;
    logic [31:0] r_ring_head;
    logic [SLOT_W-1:0] r_wr_slot;
    logic [31:0] r_open_start;
    logic [31:0] r_open_end;
    logic [31:0] r_open_count;
    logic [63:0] r_open_sum;

    // trace ring
    logic [MEM_W-1:0] r_mem [TRACE_DEPTH];
    logic [MEM_W-1:0] r_mem_q;
    logic [SLOT_W-1:0] r_rd_slot;
    logic              n_mem_we;

    // query work registers
    logic [OFF_W-1:0] r_off;
    logic [63:0] r_wsum;
    logic [31:0] r_wcnt;
    logic        r_rpm_valid;
    logic [31:0] r_mcnt;
    logic [15:0] r_mppr;
    logic [65:0] r_mscale;
    logic [79:0] r_msum;
    logic [65:0] r_nacc;
    logic [79:0] r_dacc;
    logic [5:0]  r_mstep;
    logic [33:0] r_rpm;
    logic [31:0] r_rev;
    logic [15:0] r_phase;
    logic [31:0] r_stamp;
    logic [31:0] r_now;

    t_div_req r_div_req;
    t_div_rsp w_div_rsp;

    logic n_accept;
    logic n_out_free;
    logic n_div_go;
    logic n_rpm_src;

    // pulse path
    logic [31:0] n_period;
    logic        n_take;
    logic        n_retire;
    logic [31:0] n_cnt0;
    logic [63:0] n_sum_base;
    logic [31:0] n_start;

    // walk path
    logic [31:0] n_end_t;
    logic [31:0] n_end_c;
    logic [63:0] n_end_s;
    logic        n_walk_more;
    logic        n_stale_slot;

    // query tail
    logic        n_has;
    logic        n_indexed;
    logic [31:0] n_d;
    logic [31:0] n_mag;
    logic [31:0] n_age;
    logic        n_stale;
    logic [63:0] n_stamp_prod;

    assign n_accept   = i_valid && !o_stall;
    assign n_out_free = !o_valid || !i_stall;
    assign o_stall    = (r_state != S_IDLE);

    assign n_period   = i_timestamp_us - r_last;
    assign n_take     = (r_last != 32'd0) && (n_period != 32'd0);
    assign n_retire   = n_take && (r_open_count != 32'd0) &&
                        ((i_timestamp_us - r_open_start) >= {12'd0, r_window});
    assign n_cnt0     = n_retire ? 32'd0 : r_open_count;
    assign n_sum_base = (n_cnt0 == 32'd0) ? 64'd0 : r_open_sum;
    assign n_start    = (n_cnt0 == 32'd0) ? (i_timestamp_us - n_period) : r_open_start;
    assign n_mem_we   = n_accept && (i_opcode == OP_PULSE) && n_retire;

    assign n_end_t = r_mem_q[127:96];
    assign n_end_c = r_mem_q[95:64];
    assign n_end_s = r_mem_q[63:0];
    assign n_walk_more = ({{(32-OFF_W){1'b0}}, r_off} < 32'(LOOKBACK)) &&
                         ({{(32-OFF_W){1'b0}}, r_off} < r_ring_head) &&
                         ({{(32-OFF_W){1'b0}}, r_off} < 32'(TRACE_DEPTH));
    assign n_stale_slot = (r_off != '0) && (n_end_t != 32'd0) &&
                          ((r_last - n_end_t) > FRESH_LIMIT_US);

    assign n_has     = (r_last != 32'd0) && (r_pulse_cnt != 32'd0);
    assign n_indexed = (r_index_cnt != 32'd0) && (r_index_time != 32'd0);
    assign n_d       = n_indexed ? (r_pos - r_pos_at_index) : r_pos;
    assign n_mag     = n_d[31] ? (32'd0 - n_d) : n_d;
    assign n_age     = n_has ? (r_now - r_stamp) : 32'd0;
    assign n_stale   = !n_has || (!n_age[31] && (n_age != 32'd0) && (n_age > r_timeout));
    assign n_stamp_prod = {32'd0, r_last} * {32'd0, MS_RECIP};

    assign n_rpm_src = n_has && (((r_wcnt != 32'd0) && (r_wsum != 64'd0)) ||
                                 (r_filt != 32'd0));
    assign n_div_go  = (n_mem_we && (r_open_sum != 64'd0)) ||
                       ((r_state == S_MSET) && !n_rpm_src) ||
                       ((r_state == S_MUL) && (r_mstep == 6'd32)) ||
                       (((r_state == S_DRPM) || (r_state == S_DREV)) && w_div_rsp.done);

    always_ff @(posedge i_clk) begin
        if (n_mem_we) begin
            r_mem[r_wr_slot] <= {r_open_end, r_open_count, r_open_sum};
        end
        r_mem_q <= r_mem[r_rd_slot];
    end

    setach_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_div_req),
        .o_rsp   (w_div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ppr   <= 16'd1;
            r_timeout <= 32'd1;
            r_window  <= WINDOW_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PPR:     r_ppr <= (i_cfg_data[15:0] == 16'd0) ? 16'd1 : i_cfg_data[15:0];
                CFG_TIMEOUT: r_timeout <= (i_cfg_data == 32'd0) ? 32'd1 : i_cfg_data;
                CFG_WINDOW:  r_window <= i_cfg_data[19:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_last           <= '0;
            r_raw            <= '0;
            r_filt           <= '0;
            r_pulse_cnt      <= '0;
            r_index_cnt      <= '0;
            r_pulse_at_index <= '0;
            r_index_span     <= '0;
            r_pos            <= '0;
            r_pos_at_index   <= '0;
            r_index_time     <= '0;
            r_dir            <= '0;
            r_ring_head      <= '0;
            r_wr_slot        <= '0;
            r_open_start     <= '0;
            r_open_end       <= '0;
            r_open_count     <= '0;
            r_open_sum       <= '0;
            r_div_req        <= '0;
            o_valid          <= 1'b0;
        end else begin
            r_div_req.start <= n_div_go;
            o_valid         <= ((r_state == S_DONE) && n_out_free) || (o_valid && i_stall);
            unique case (r_state)
                S_IDLE: begin
                    if (n_accept && i_opcode == OP_PULSE) begin
                        r_last      <= i_timestamp_us;
                        r_pulse_cnt <= r_pulse_cnt + 32'd1;
                        if (i_direction != 2'sd0) begin
                            r_dir <= (i_direction == 2'sd1) ? 2'b01 : 2'b11;
                            r_pos <= (i_direction == 2'sd1) ? r_pos + 32'd1 : r_pos - 32'd1;
                        end
                        if (n_take) begin
                            r_raw        <= n_period;
                            r_open_start <= n_start;
                            r_open_end   <= i_timestamp_us;
                            r_open_count <= n_cnt0 + 32'd1;
                            r_open_sum   <= n_sum_base + {32'd0, n_period};
                        end
                        if (n_retire) begin
                            r_ring_head <= r_ring_head + 32'd1;
                            r_wr_slot   <= (r_wr_slot == SLOT_W'(TRACE_DEPTH - 1)) ?
                                           '0 : r_wr_slot + 1'b1;
                            if (r_open_sum != 64'd0) begin
                                r_div_req.num   <= {r_open_sum, 2'b00};
                                r_div_req.den   <= {48'd0, r_open_count};
                                r_div_req.iter  <= IT_W'(64);
                                r_state         <= S_FILT;
                            end
                        end
                    end else if (n_accept && i_opcode == OP_INDEX) begin
                        r_pulse_at_index <= r_pulse_cnt;
                        if (r_index_cnt != 32'd0) begin
                            r_index_span <= r_pulse_cnt - r_pulse_at_index;
                        end
                        r_pos_at_index <= r_pos;
                        r_index_time   <= i_timestamp_us;
                        r_index_cnt    <= r_index_cnt + 32'd1;
                    end else if (n_accept && i_opcode == OP_QUERY) begin
                        r_off     <= '0;
                        r_wsum    <= '0;
                        r_wcnt    <= '0;
                        r_now     <= i_now_ms;
                        r_rd_slot <= (r_wr_slot == '0) ? SLOT_W'(TRACE_DEPTH - 1) :
                                     r_wr_slot - 1'b1;
                        r_state   <= S_WRD;
                    end
                end
                S_FILT: begin
                    if (w_div_rsp.done) begin
                        r_filt  <= w_div_rsp.quo[31:0];
                        r_state <= S_IDLE;
                    end
                end
                S_WRD: begin
                    // slot data is registered and shows up in r_mem_q in the next cycle
                    r_state <= n_walk_more ? S_WCHK : S_MSET;
                end
                S_WCHK: begin
                    if (n_stale_slot) begin
                        r_state <= S_MSET;
                    end else begin
                        r_wsum    <= r_wsum + n_end_s;
                        r_wcnt    <= r_wcnt + n_end_c;
                        r_off     <= r_off + 1'b1;
                        r_rd_slot <= (r_rd_slot == '0) ? SLOT_W'(TRACE_DEPTH - 1) :
                                     r_rd_slot - 1'b1;
                        r_state   <= S_WRD;
                    end
                end
                S_MSET: begin
                    r_mppr   <= r_ppr;
                    r_mscale <= {32'd0, RPM_SCALE};
                    r_nacc   <= '0;
                    r_dacc   <= '0;
                    r_mstep  <= '0;
                    r_rpm    <= '0;
                    if (n_has && r_wcnt != 32'd0 && r_wsum != 64'd0) begin
                        r_rpm_valid <= 1'b1;
                        r_mcnt      <= r_wcnt;
                        r_msum      <= {16'd0, r_wsum};
                        r_state     <= S_MUL;
                    end else if (n_has && r_filt != 32'd0) begin
                        r_rpm_valid <= 1'b1;
                        r_mcnt      <= 32'd1;
                        r_msum      <= {48'd0, r_filt};
                        r_state     <= S_MUL;
                    end else begin
                        r_rpm_valid     <= 1'b0;
                        r_div_req.num   <= {r_pulse_cnt, 34'd0};
                        r_div_req.den   <= {64'd0, r_ppr};
                        r_div_req.iter  <= IT_W'(32);
                        r_state         <= S_DREV;
                    end
                end
                S_MUL: begin
                    // shift-add: count times scale, sum times pulses per rev
                    if (r_mcnt[0]) r_nacc <= r_nacc + r_mscale;
                    if (r_mppr[0]) r_dacc <= r_dacc + r_msum;
                    r_mcnt   <= {1'b0, r_mcnt[31:1]};
                    r_mppr   <= {1'b0, r_mppr[15:1]};
                    r_mscale <= {r_mscale[64:0], 1'b0};
                    r_msum   <= {r_msum[78:0], 1'b0};
                    r_mstep  <= r_mstep + 1'b1;
                    if (r_mstep == 6'd32) begin
                        r_div_req.num   <= r_nacc;
                        r_div_req.den   <= r_dacc;
                        r_div_req.iter  <= IT_W'(NUM_W);
                        r_state         <= S_DRPM;
                    end
                end
                S_DRPM: begin
                    if (w_div_rsp.done) begin
                        r_rpm <= (w_div_rsp.quo > {32'd0, RPM_MAX}) ? RPM_MAX :
                                 w_div_rsp.quo[33:0];
                        r_div_req.num   <= {r_pulse_cnt, 34'd0};
                        r_div_req.den   <= {64'd0, r_ppr};
                        r_div_req.iter  <= IT_W'(32);
                        r_state         <= S_DREV;
                    end
                end
                S_DREV: begin
                    if (w_div_rsp.done) begin
                        r_rev           <= w_div_rsp.quo[31:0];
                        r_div_req.num   <= {n_mag, 34'd0};
                        r_div_req.den   <= {64'd0, r_ppr};
                        r_div_req.iter  <= IT_W'(32);
                        r_state         <= S_DMOD;
                    end
                end
                S_DMOD: begin
                    if (w_div_rsp.done) begin
                        // floor modulo for a negative position
                        r_phase <= (n_d[31] && w_div_rsp.rem[15:0] != 16'd0) ?
                                   r_ppr - w_div_rsp.rem[15:0] : w_div_rsp.rem[15:0];
                        r_state <= S_DMS;
                    end
                end
                S_DMS: begin
                    // last pulse time in ms by reciprocal multiply
                    r_stamp <= {6'd0, n_stamp_prod[63:38]};
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (n_out_free) begin
                        o_pulse_total      <= r_pulse_cnt;
                        o_index_total      <= r_index_cnt;
                        o_pulses_per_index <= r_index_span;
                        o_raw_period       <= r_raw;
                        o_filtered_period  <= r_filt;
                        o_windows_retired  <= r_ring_head;
                        o_last_direction   <= r_dir;
                        o_rpm_fixed        <= r_rpm_valid ? r_rpm : 34'd0;
                        o_revolutions      <= r_rev;
                        o_phase_pulses     <= r_phase;
                        o_pulse_age_ms     <= n_age;
                        o_status_flags     <= {n_stale, n_indexed, n_has,
                                               r_index_cnt != 32'd0, r_rpm_valid,
                                               r_dir != 2'b00};
                        r_state            <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state) == S_DONE)
        else $error("result raised outside the done state");

    a_head_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ring_head != $past(r_ring_head)) |-> (r_ring_head == $past(r_ring_head) + 32'd1))
        else $error("ring head moved by more than one");

    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_req.start |=> (r_state == S_FILT || r_state == S_DRPM ||
                             r_state == S_DREV || r_state == S_DMOD || r_state == S_DMS))
        else $error("divider started without a state waiting on it");

    a_ring_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_mem_we |-> (r_state == S_IDLE && i_opcode == OP_PULSE))
        else $error("trace ring written outside a pulse transfer");

endmodule

// ----- tb/spindle_encoder_tachometer_checker.sv -----
module spindle_encoder_tachometer_checker
    import setach_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_in_stall,
    input  logic [1:0]         i_opcode,
    input  logic [31:0]        i_timestamp_us,
    input  logic signed [1:0]  i_direction,
    input  logic [31:0]        i_now_ms,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [31:0]        i_pulse_total,
    input  logic [31:0]        i_index_total,
    input  logic [31:0]        i_pulses_per_index,
    input  logic [31:0]        i_raw_period,
    input  logic [31:0]        i_filtered_period,
    input  logic [31:0]        i_windows_retired,
    input  logic signed [1:0]  i_last_direction,
    input  logic [33:0]        i_rpm_fixed,
    input  logic [31:0]        i_revolutions,
    input  logic [15:0]        i_phase_pulses,
    input  logic [31:0]        i_pulse_age_ms,
    input  logic [5:0]         i_status_flags,
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam int RING_DEPTH = TRACE_DEPTH_DEF;
    localparam int FLAG_DIR     = 0;
    localparam int FLAG_RPM     = 1;
    localparam int FLAG_INDEX   = 2;
    localparam int FLAG_POS     = 3;
    localparam int FLAG_ANGLE   = 4;
    localparam int FLAG_STALE   = 5;

    typedef struct packed {
        logic [31:0] pulse_total;
        logic [31:0] index_total;
        logic [31:0] pulses_per_index;
        logic [31:0] raw_period;
        logic [31:0] filtered_period;
        logic [31:0] windows_retired;
        logic [1:0]  last_direction;
        logic [33:0] rpm_fixed;
        logic [31:0] revolutions;
        logic [15:0] phase_pulses;
        logic [31:0] pulse_age_ms;
        logic [5:0]  status_flags;
    } t_status;

    t_status status_q[$];

    logic [15:0] ppr;
    logic [31:0] timeout_ms;
    logic [19:0] window_len;

    logic [31:0] last_ts, raw_per, filt_per, pulse_cnt, index_cnt, pulses_at_idx, idx_span;
    logic [31:0] position, pos_at_idx, idx_ts, head, win_start, win_end, win_cnt;
    logic [63:0] win_sum;
    logic [1:0]  dir_q;
    logic [31:0] ring_end[RING_DEPTH];
    logic [31:0] ring_cnt[RING_DEPTH];
    logic [63:0] ring_sum[RING_DEPTH];
    logic [31:0] ring_seq[RING_DEPTH];

    assign o_pending = status_q.size();

    function automatic void retire_window();
        logic [31:0] seq;
        int slot;
        seq = head + 1;
        slot = int'((seq - 1) % RING_DEPTH);
        ring_end[slot] = win_end;
        ring_cnt[slot] = win_cnt;
        ring_sum[slot] = win_sum;
        ring_seq[slot] = seq;
        if (win_cnt != 0 && win_sum != 0)
            filt_per = 32'(win_sum / win_cnt);
        head = seq;
        win_cnt = 0;
    endfunction

    function automatic void take_pulse(logic [31:0] ts, logic [1:0] dir);
        logic [31:0] prev, period;
        prev = last_ts;
        period = ts - prev;
        last_ts = ts;
        if (prev != 0 && period != 0) begin
            raw_per = period;
            if (win_cnt != 0 && (ts - win_start) >= {12'd0, window_len})
                retire_window();
            if (win_cnt == 0) begin
                win_start = ts - period;
                win_sum = 0;
            end
            win_end = ts;
            win_cnt++;
            win_sum += period;
        end
        pulse_cnt++;
        if (dir != 0) begin
            // 01 is forward, any negative code is reverse
            dir_q = (dir == 2'b01) ? 2'b01 : 2'b11;
            position += (dir == 2'b01) ? 32'd1 : 32'hFFFF_FFFF;
        end
    endfunction

    function automatic t_status status_report(logic [31:0] now);
        t_status s;
        logic pulses_seen, rpm_ok, indexed, stale;
        logic [63:0] sum;
        logic [31:0] cnt, seq, age, diff;
        logic [127:0] num, den, quo;
        int slot;
        longint d, r;
        pulses_seen = last_ts != 0 && pulse_cnt != 0;
        indexed = index_cnt != 0 && idx_ts != 0;
        sum = 0;
        cnt = 0;
        rpm_ok = 0;
        quo = 0;
        // newest window first, stop at an overwritten slot or an old window
        for (int off = 0; off < LOOKBACK_DEF && off < head; off++) begin
            seq = head - off;
            slot = int'((seq - 1) % RING_DEPTH);
            if (ring_seq[slot] != seq) break;
            if (off != 0 && ring_end[slot] != 0 &&
                (last_ts - ring_end[slot]) > FRESH_LIMIT_US) break;
            sum += ring_sum[slot];
            cnt += ring_cnt[slot];
        end
        if (pulses_seen && cnt != 0 && sum != 0) begin
            num = 128'(RPM_SCALE) * 128'(cnt);
            den = 128'(sum) * 128'(ppr);
            quo = num / den;
            rpm_ok = 1;
        end else if (pulses_seen && filt_per != 0) begin
            num = 128'(RPM_SCALE);
            den = 128'(filt_per) * 128'(ppr);
            quo = num / den;
            rpm_ok = 1;
        end
        if (quo > 128'(RPM_MAX)) quo = 128'(RPM_MAX);
        diff = indexed ? position - pos_at_idx : position;
        d = longint'($signed(diff));
        r = d % longint'(ppr);
        if (r < 0) r += longint'(ppr);
        age = pulses_seen ? now - last_ts / 32'(US_PER_MS) : 32'd0;
        stale = !pulses_seen || (!age[31] && age != 0 && age > timeout_ms);
        s.pulse_total      = pulse_cnt;
        s.index_total      = index_cnt;
        s.pulses_per_index = idx_span;
        s.raw_period       = raw_per;
        s.filtered_period  = filt_per;
        s.windows_retired  = head;
        s.last_direction   = dir_q;
        s.rpm_fixed        = quo[33:0];
        s.revolutions      = pulse_cnt / ppr;
        s.phase_pulses     = 16'(r);
        s.pulse_age_ms     = age;
        s.status_flags     = '0;
        s.status_flags[FLAG_DIR]   = dir_q != 0;
        s.status_flags[FLAG_RPM]   = rpm_ok;
        s.status_flags[FLAG_INDEX] = index_cnt != 0;
        s.status_flags[FLAG_POS]   = pulses_seen;
        s.status_flags[FLAG_ANGLE] = indexed;
        s.status_flags[FLAG_STALE] = stale;
        return s;
    endfunction

    task automatic cmp(string name, logic [63:0] exp_v, logic [63:0] got_v);
        if (exp_v !== got_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, got_v);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ppr = 1;
            timeout_ms = 1;
            window_len = WINDOW_RESET;
            {last_ts, raw_per, filt_per, pulse_cnt, index_cnt} = '0;
            {pulses_at_idx, idx_span, position, pos_at_idx, idx_ts} = '0;
            {head, win_start, win_end, win_cnt, win_sum, dir_q} = '0;
            for (int k = 0; k < RING_DEPTH; k++) ring_seq[k] = 0;
            status_q.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PPR:     ppr = (i_cfg_data[15:0] == 0) ? 16'd1 : i_cfg_data[15:0];
                    CFG_TIMEOUT: timeout_ms = (i_cfg_data == 0) ? 32'd1 : i_cfg_data;
                    CFG_WINDOW:  window_len = i_cfg_data[19:0];
                    default: ;
                endcase
            end
            if (i_valid && !i_in_stall) begin
                case (i_opcode)
                    OP_PULSE: take_pulse(i_timestamp_us, i_direction);
                    OP_INDEX: begin
                        if (index_cnt != 0) idx_span = pulse_cnt - pulses_at_idx;
                        pulses_at_idx = pulse_cnt;
                        pos_at_idx = position;
                        idx_ts = i_timestamp_us;
                        index_cnt++;
                    end
                    OP_QUERY: status_q.push_back(status_report(i_now_ms));
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (status_q.size() == 0) begin
                    $error("status transfer with nothing expected");
                    o_fail_count++;
                end else begin
                    t_status e;
                    e = status_q.pop_front();
                    cmp("pulse_total", e.pulse_total, i_pulse_total);
                    cmp("index_total", e.index_total, i_index_total);
                    cmp("pulses_per_index", e.pulses_per_index, i_pulses_per_index);
                    cmp("raw_period", e.raw_period, i_raw_period);
                    cmp("filtered_period", e.filtered_period, i_filtered_period);
                    cmp("windows_retired", e.windows_retired, i_windows_retired);
                    cmp("last_direction", e.last_direction, $unsigned(i_last_direction));
                    cmp("rpm_fixed", e.rpm_fixed, i_rpm_fixed);
                    cmp("revolutions", e.revolutions, i_revolutions);
                    cmp("phase_pulses", e.phase_pulses, i_phase_pulses);
                    cmp("pulse_age_ms", e.pulse_age_ms, i_pulse_age_ms);
                    cmp("status_flags", e.status_flags, i_status_flags);
                end
            end
        end
    end

endmodule

// ----- tb/tb_spindle_encoder_tachometer_top.sv -----
module tb_spindle_encoder_tachometer_top;
    import setach_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic signed [1:0] DIR_NONE = 2'sb00;
    localparam logic signed [1:0] DIR_FWD  = 2'sb01;
    localparam logic signed [1:0] DIR_REV  = 2'sb11;
    localparam logic signed [1:0] DIR_REV2 = 2'sb10;
    localparam int RANDOM_ITEMS = 930;
    localparam int DRAIN_CYCLES = 400;
    localparam longint CYCLE_LIMIT = 3_000_000;

    logic i_clk, i_rst_n, i_valid, o_stall, i_cfg_we, o_valid;
    logic i_stall = 1'b0;
    logic [1:0] i_opcode, i_cfg_index;
    logic [31:0] i_timestamp_us, i_now_ms, i_cfg_data;
    logic signed [1:0] i_direction, o_last_direction;
    logic [31:0] o_pulse_total, o_index_total, o_pulses_per_index, o_raw_period;
    logic [31:0] o_filtered_period, o_windows_retired, o_revolutions, o_pulse_age_ms;
    logic [33:0] o_rpm_fixed;
    logic [15:0] o_phase_pulses;
    logic [5:0] o_status_flags;
    int fail_count, pending;
    longint cycles = 0;
    logic [31:0] enc_ts;
    logic burst_mode;

    spindle_encoder_tachometer_top dut (.*);

    spindle_encoder_tachometer_checker u_checker (
        .i_clk, .i_rst_n, .i_valid, .i_in_stall(o_stall), .i_opcode, .i_timestamp_us,
        .i_direction, .i_now_ms, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_out_valid(o_valid), .i_out_stall(i_stall), .i_pulse_total(o_pulse_total),
        .i_index_total(o_index_total), .i_pulses_per_index(o_pulses_per_index),
        .i_raw_period(o_raw_period), .i_filtered_period(o_filtered_period),
        .i_windows_retired(o_windows_retired), .i_last_direction(o_last_direction),
        .i_rpm_fixed(o_rpm_fixed), .i_revolutions(o_revolutions),
        .i_phase_pulses(o_phase_pulses), .i_pulse_age_ms(o_pulse_age_ms),
        .i_status_flags(o_status_flags), .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (burst_mode || p < 55) return 0;
        if (p < 88) return $urandom_range(1, 3);
        if (p < 98) return $urandom_range(4, 20);
        return $urandom_range(30, 90);
    endfunction

    // result side stall pattern
    int stall_left = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_spindle_encoder_tachometer_top: errors");
            $finish;
        end
        if (stall_left == 0) begin
            i_stall <= burst_mode ? 1'b0 : ($urandom_range(0, 2) == 0);
            stall_left <= gap_len();
        end else begin
            stall_left <= stall_left - 1;
        end
    end

    task automatic send(logic [1:0] op, logic [31:0] ts, logic [1:0] dir, logic [31:0] now);
        int g;
        i_valid <= 1'b1;
        i_opcode <= op;
        i_timestamp_us <= ts;
        i_direction <= dir;
        i_now_ms <= now;
        do @(posedge i_clk); while (o_stall);
        g = gap_len();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic pulse_at(logic [31:0] ts, logic [1:0] dir);
        send(OP_PULSE, ts, dir, $urandom());
    endtask

    task automatic query(logic [31:0] now);
        send(OP_QUERY, $urandom(), $urandom(), now);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // hold input until all status transfers are back, then let a division finish
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_item();
        int p;
        logic [31:0] step;
        p = $urandom_range(0, 99);
        if (p < 58) begin
            p = $urandom_range(0, 99);
            if (p < 80) step = $urandom_range(1, 4000);
            else if (p < 86) step = 0;
            else if (p < 94) step = $urandom_range(20000, 300000);
            else step = $urandom();
            enc_ts = enc_ts + step;
            pulse_at(enc_ts, $urandom());
        end else if (p < 66) begin
            send(OP_INDEX, ($urandom_range(0, 20) == 0) ? 32'd0 : enc_ts + 7, $urandom(),
                 $urandom());
        end else if (p < 96) begin
            query(($urandom_range(0, 3) == 0) ? $urandom()
                                              : enc_ts / 1000 + $urandom_range(0, 40));
        end else begin
            send(OP_UNUSED, $urandom(), $urandom(), $urandom());
        end
    endtask

    initial begin
        logic [15:0] ppr_set[5];
        logic [31:0] tmo_set[5];
        logic [31:0] win_set[5];
        ppr_set = '{16'd1, 16'd65535, 16'd0, 16'd7, 16'd360};
        tmo_set = '{32'd1, 32'hFFFF_FFFF, 32'd0, 32'd50, 32'd1000};
        win_set = '{32'd0, 32'd1, 32'd1000000, 32'd10000, 32'd3000};
        burst_mode = 0;
        i_rst_n = 0;
        i_valid = 0;
        i_opcode = OP_PULSE;
        i_timestamp_us = 0;
        i_direction = DIR_NONE;
        i_now_ms = 0;
        i_cfg_we = 0;
        i_cfg_index = CFG_PPR;
        i_cfg_data = 0;
        enc_ts = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty status, zero timestamp, direction codes, wrap, index span
        query(32'd0);
        send(OP_INDEX, 32'd0, DIR_NONE, 32'd0);
        pulse_at(32'd0, DIR_FWD);
        query(32'hFFFF_FFFF);
        pulse_at(32'd1000, DIR_REV);
        pulse_at(32'd1000, DIR_REV2);
        pulse_at(32'd4000, DIR_NONE);
        pulse_at(32'd14500, DIR_FWD);
        send(OP_INDEX, 32'd15000, DIR_NONE, 32'd0);
        pulse_at(32'd30000, DIR_REV);
        pulse_at(32'hFFFF_FFF0, DIR_FWD);
        pulse_at(32'd5, DIR_FWD);
        send(OP_INDEX, 32'hFFFF_FFFF, DIR_NONE, 32'd0);
        query(32'd0);
        send(OP_UNUSED, 32'hFFFF_FFFF, DIR_REV, 32'hFFFF_FFFF);
        query(32'd100000);
        enc_ts = 32'd100;

        for (int ph = 0; ph < 5; ph++) begin
            settle();
            write_reg(CFG_PPR, {16'hFFFF, ppr_set[ph]});
            write_reg(CFG_TIMEOUT, tmo_set[ph]);
            write_reg(CFG_WINDOW, (ph == 4) ? {12'd0, 20'($urandom())} : win_set[ph]);
            for (int n = 0; n < RANDOM_ITEMS / 5; n++) begin
                if ($urandom_range(0, 60) == 0) burst_mode = ~burst_mode;
                random_item();
            end
            burst_mode = 0;
        end

        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb_spindle_encoder_tachometer_top: clean");
        else
            $display("tb_spindle_encoder_tachometer_top: errors");
        $finish;
    end

endmodule
